>>> hw/rtl/i2cee_pkg.sv
// Shared types, register map and reset values for the EEPROM byte master.
package i2cee_pkg;

	localparam int CFG_WIDTH = 16;
	localparam int IDX_WIDTH = 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef logic [IDX_WIDTH-1:0] reg_idx_t;

	localparam reg_idx_t REG_DEVICE_ADDRESS = 3'd0;
	localparam reg_idx_t REG_ACK_TIMEOUT    = 3'd1;
	localparam reg_idx_t REG_PHASE_TICKS    = 3'd2;
	localparam reg_idx_t REG_WRITE_RECOVERY = 3'd3;
	localparam reg_idx_t REG_READ_RECOVERY  = 3'd4;

	localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd80;
	localparam logic [7:0]  RST_ACK_TIMEOUT    = 8'd255;
	localparam logic [7:0]  RST_PHASE_TICKS    = 8'd1;
	localparam logic [15:0] RST_WRITE_RECOVERY = 16'd50;
	localparam logic [15:0] RST_READ_RECOVERY  = 16'd10;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START    = 4'd1,
		PH_DEVW     = 4'd2,
		PH_ACKDEVW  = 4'd3,
		PH_ADDR     = 4'd4,
		PH_ACKADDR  = 4'd5,
		PH_DATA     = 4'd6,
		PH_ACKDATA  = 4'd7,
		PH_RSTART   = 4'd8,
		PH_DEVR     = 4'd9,
		PH_ACKDEVR  = 4'd10,
		PH_READ     = 4'd11,
		PH_NACK     = 4'd12,
		PH_STOP     = 4'd13,
		PH_RECOVER  = 4'd14
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       mode;
		logic [7:0] mem_address;
		logic [7:0] write_data;
		logic       sda_sample;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} res_t;

	// queue entry: beat already decoded into an operation
	typedef struct packed {
		op_t        op;
		logic [7:0] mem_address;
		logic [7:0] write_data;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [7:0]  ack_timeout;
		logic [7:0]  phase_ticks;
		logic [15:0] write_recovery;
		logic [15:0] read_recovery;
	} cfg_t;

	typedef struct packed {
		logic clk;
		logic dat;
	} lines_t;

endpackage

>>> hw/rtl/i2cee_ifs.sv
// Valid/ready channel interfaces for command beats and result beats.
interface i2cee_cmd_if;
	import i2cee_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface i2cee_res_if;
	import i2cee_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/i2cee_front.sv
// Front end: decodes incoming beats and queues them for the bus sequencer.
module i2cee_front (
	input  logic                 clk,
	input  logic                 arst_n,
	i2cee_cmd_if.sink            tick,
	output logic                 item_valid,
	input  logic                 item_ready,
	output i2cee_pkg::item_t     item
);
	import i2cee_pkg::*;

	item_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;
	item_t               item_in;

	always_comb begin
		item_in.mem_address = tick.data.mem_address;
		item_in.write_data  = tick.data.write_data;
		item_in.sda_sample  = tick.data.sda_sample;
		if (!tick.data.cmd_valid) begin
			item_in.op = OP_NONE;
		end else if (tick.data.mode) begin
			item_in.op = OP_READ;
		end else begin
			item_in.op = OP_WRITE;
		end
	end

	assign tick.ready = (count_q != QCNT_W'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign push       = tick.valid && tick.ready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/i2cee_back.sv
// Back end: bus phase sequencer, one tick per beat, with a registered result.
module i2cee_back (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cee_pkg::cfg_t   cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  i2cee_pkg::item_t  item,
	i2cee_res_if.source       result
);
	import i2cee_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  slot_q, slot_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] wait_q, wait_d;
	logic        mode_q, mode_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  data_q, data_d;
	logic        err_q, err_d;
	lines_t      lines_q, lines_d;
	logic        res_valid_q;
	res_t        res_q, res_d;

	logic        step;
	logic        done;
	logic        apply_en;
	logic        enter_en;
	phase_t      enter_ph;
	logic [1:0]  enter_slot;
	logic [15:0] hold;
	logic [15:0] wait_inc;

	function automatic logic is_ack(phase_t ph);
		return ph == PH_ACKDEVW || ph == PH_ACKADDR || ph == PH_ACKDATA || ph == PH_ACKDEVR;
	endfunction

	// line levels driven on entry to a slot
	function automatic lines_t apply_slot(phase_t ph, logic [1:0] s, logic [3:0] bc,
			logic [7:0] sh, lines_t cur);
		lines_t l;
		l = cur;
		unique case (ph)
			PH_START, PH_RSTART: begin
				case (s)
					2'd0:    l.dat = 1'b1;
					2'd1:    l.clk = 1'b1;
					2'd2:    l.dat = 1'b0;
					default: l.clk = 1'b0;
				endcase
			end
			PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
				case (s)
					2'd0:    l.clk = 1'b0;
					2'd1:    l.dat = (bc < 4'd8) ? sh[7] : 1'b1;
					default: l.clk = 1'b1;
				endcase
			end
			PH_ACKDEVW, PH_ACKADDR, PH_ACKDATA, PH_ACKDEVR: begin
				if (s == 2'd0) begin
					l.clk = 1'b1;
					l.dat = 1'b1;
				end else begin
					l.clk = 1'b0;
				end
			end
			PH_READ: begin
				case (s)
					2'd0:    l.clk = 1'b0;
					2'd1:    l.dat = 1'b1;
					2'd2:    l.clk = 1'b1;
					default: l.clk = 1'b0;
				endcase
			end
			PH_NACK: begin
				case (s)
					2'd0:    l.dat = 1'b1;
					2'd1:    l.clk = 1'b1;
					default: l.clk = 1'b0;
				endcase
			end
			PH_STOP: begin
				case (s)
					2'd0:    l.dat = 1'b0;
					2'd1:    l.clk = 1'b1;
					default: l.dat = 1'b1;
				endcase
			end
			default: begin
				l.clk = 1'b1;
				l.dat = 1'b1;
			end
		endcase
		return l;
	endfunction

	assign item_ready   = !res_valid_q || result.ready;
	assign step         = item_valid && item_ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign hold     = (cfg.phase_ticks == 8'd0) ? 16'd0 : {8'd0, cfg.phase_ticks - 8'd1};
	assign wait_inc = wait_q + 16'd1;

	// next state
	always_comb begin
		phase_d    = phase_q;
		slot_d     = slot_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		wait_d     = wait_q;
		mode_d     = mode_q;
		addr_d     = addr_q;
		data_d     = data_q;
		err_d      = err_q;
		apply_en   = 1'b0;
		done       = 1'b0;
		enter_en   = 1'b0;
		enter_ph   = phase_q;
		enter_slot = slot_q;

		if (phase_q == PH_IDLE) begin
			if (item.op != OP_NONE) begin
				mode_d     = (item.op == OP_READ);
				addr_d     = item.mem_address;
				data_d     = item.write_data;
				err_d      = 1'b0;
				shift_d    = 8'd0;
				enter_en   = 1'b1;
				enter_ph   = PH_START;
				enter_slot = 2'd0;
			end
		end else if (phase_q == PH_RECOVER) begin
			if (wait_q == 16'd0) begin
				phase_d = PH_IDLE;
				done    = 1'b1;
			end else begin
				wait_d = wait_q - 16'd1;
			end
		end else if (is_ack(phase_q) && slot_q == 2'd0) begin
			// clock held high until the device pulls data low or timeout
			if (!item.sda_sample) begin
				enter_en   = 1'b1;
				enter_slot = 2'd1;
			end else begin
				wait_d = wait_inc;
				if (wait_inc >= {8'd0, cfg.ack_timeout}) begin
					err_d      = 1'b1;
					enter_en   = 1'b1;
					enter_slot = 2'd1;
				end
			end
		end else if (wait_q != 16'd0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			unique case (phase_q)
				PH_START, PH_RSTART: begin
					enter_en = 1'b1;
					if (slot_q < 2'd3) begin
						enter_slot = slot_q + 2'd1;
					end else begin
						shift_d    = {cfg.device_address, phase_q == PH_RSTART};
						bit_d      = 4'd0;
						enter_ph   = (phase_q == PH_START) ? PH_DEVW : PH_DEVR;
						enter_slot = 2'd0;
					end
				end
				PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
					if (bit_q < 4'd8) begin
						enter_en = 1'b1;
						if (slot_q < 2'd2) begin
							enter_slot = slot_q + 2'd1;
						end else begin
							shift_d    = {shift_q[6:0], 1'b0};
							bit_d      = bit_q + 4'd1;
							enter_slot = 2'd0;
						end
					end else if (slot_q < 2'd1) begin
						enter_en   = 1'b1;
						enter_slot = 2'd1;
					end else begin
						// ack phase directly follows its send phase
						phase_d  = phase_t'(4'(phase_q) + 4'd1);
						slot_d   = 2'd0;
						wait_d   = 16'd0;
						apply_en = 1'b1;
					end
				end
				PH_ACKDEVW: begin
					shift_d    = addr_q;
					bit_d      = 4'd0;
					enter_en   = 1'b1;
					enter_ph   = PH_ADDR;
					enter_slot = 2'd0;
				end
				PH_ACKADDR: begin
					enter_en   = 1'b1;
					enter_slot = 2'd0;
					if (mode_q) begin
						enter_ph = PH_RSTART;
					end else begin
						shift_d  = data_q;
						bit_d    = 4'd0;
						enter_ph = PH_DATA;
					end
				end
				PH_ACKDATA: begin
					enter_en   = 1'b1;
					enter_ph   = PH_STOP;
					enter_slot = 2'd0;
				end
				PH_ACKDEVR: begin
					bit_d      = 4'd0;
					shift_d    = 8'd0;
					enter_en   = 1'b1;
					enter_ph   = PH_READ;
					enter_slot = 2'd0;
				end
				PH_READ: begin
					enter_en = 1'b1;
					if (slot_q < 2'd2) begin
						enter_slot = slot_q + 2'd1;
					end else if (slot_q == 2'd2) begin
						shift_d    = {shift_q[6:0], item.sda_sample};
						enter_slot = 2'd3;
					end else if (bit_q < 4'd7) begin
						bit_d      = bit_q + 4'd1;
						enter_slot = 2'd2;
					end else begin
						enter_ph   = PH_NACK;
						enter_slot = 2'd0;
					end
				end
				PH_NACK: begin
					enter_en = 1'b1;
					if (slot_q < 2'd2) begin
						enter_slot = slot_q + 2'd1;
					end else begin
						enter_ph   = PH_STOP;
						enter_slot = 2'd0;
					end
				end
				PH_STOP: begin
					if (slot_q < 2'd2) begin
						enter_en   = 1'b1;
						enter_slot = slot_q + 2'd1;
					end else begin
						phase_d  = PH_RECOVER;
						slot_d   = 2'd0;
						apply_en = 1'b1;
						wait_d   = mode_q ? cfg.read_recovery : cfg.write_recovery;
					end
				end
				default: begin
					phase_d  = PH_IDLE;
					slot_d   = 2'd0;
					wait_d   = 16'd0;
					apply_en = 1'b1;
				end
			endcase
		end

		if (enter_en) begin
			phase_d  = enter_ph;
			slot_d   = enter_slot;
			wait_d   = hold;
			apply_en = 1'b1;
		end
	end

	// outputs
	always_comb begin
		lines_d = apply_en ? apply_slot(phase_d, slot_d, bit_d, shift_d, lines_q) : lines_q;
		res_d.scl_level   = lines_d.clk;
		res_d.sda_release = lines_d.dat;
		res_d.busy_res    = (phase_d != PH_IDLE);
		res_d.done_res    = done;
		res_d.read_data   = (done && mode_q) ? shift_q : 8'd0;
		res_d.ack_missing = done && err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			slot_q      <= 2'd0;
			bit_q       <= 4'd0;
			shift_q     <= 8'd0;
			wait_q      <= 16'd0;
			mode_q      <= 1'b0;
			addr_q      <= 8'd0;
			data_q      <= 8'd0;
			err_q       <= 1'b0;
			lines_q     <= '{clk: 1'b1, dat: 1'b1};
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_d;
				slot_q      <= slot_d;
				bit_q       <= bit_d;
				shift_q     <= shift_d;
				wait_q      <= wait_d;
				mode_q      <= mode_d;
				addr_q      <= addr_d;
				data_q      <= data_d;
				err_q       <= err_d;
				lines_q     <= lines_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

endmodule

>>> hw/rtl/i2c_eeprom_byte_master_core.sv
// Top level: config registers, beat queue and bus sequencer for the EEPROM byte master.
// A tick beat is held in the queue; its result beat is registered once the sequencer takes it.
// Throughput: one tick beat per cycle, and one bus tick per cycle, while results are taken.
// The two-entry queue keeps accepting ticks while a result waits to be taken, until it is full.
// Reset: queue emptied, sequencer idle with both bus lines released, registers
// return to their defaults.
module i2c_eeprom_byte_master_core (
	input  logic                               clk,
	input  logic                               arst_n,
	i2cee_cmd_if.sink                          tick,
	i2cee_res_if.source                        result,
	input  logic                               wr_en,
	input  i2cee_pkg::reg_idx_t                wr_index,
	input  logic [i2cee_pkg::CFG_WIDTH-1:0]    wr_data
);
	import i2cee_pkg::*;

	cfg_t  cfg_q;
	logic  item_valid;
	logic  item_ready;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= RST_DEVICE_ADDRESS;
			cfg_q.ack_timeout    <= RST_ACK_TIMEOUT;
			cfg_q.phase_ticks    <= RST_PHASE_TICKS;
			cfg_q.write_recovery <= RST_WRITE_RECOVERY;
			cfg_q.read_recovery  <= RST_READ_RECOVERY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= wr_data[6:0];
				REG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= wr_data[7:0];
				REG_PHASE_TICKS:    cfg_q.phase_ticks    <= wr_data[7:0];
				REG_WRITE_RECOVERY: cfg_q.write_recovery <= wr_data;
				REG_READ_RECOVERY:  cfg_q.read_recovery  <= wr_data;
				default: ;
			endcase
		end
	end

	i2cee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	i2cee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.result     (result)
	);

endmodule

>>> tb/i2c_eeprom_byte_master_core_test.sv
// Self-checking testbench for the EEPROM byte master core: tick beats in, bus level beats out.
`timescale 1ns / 100ps

module i2c_eeprom_byte_master_core_test;
	import i2cee_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int PRINT_CAP   = 40;

	typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

	logic     clk;
	logic     arst_n;
	logic     wr_en;
	reg_idx_t wr_index;
	logic [CFG_WIDTH-1:0] wr_data;

	i2cee_cmd_if tick_bus();
	i2cee_res_if res_bus();

	i2c_eeprom_byte_master_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_bus),
		.result   (res_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// sequencer mirror
	cfg_t        sq_cfg;
	phase_t      sq_phase;
	logic [3:0]  sq_bits;
	logic [7:0]  sq_shift;
	logic [15:0] sq_wait;
	logic [1:0]  sq_slot;
	logic        sq_mode;
	logic [7:0]  sq_addr;
	logic [7:0]  sq_data;
	logic        sq_ack_err;
	logic        sq_scl;
	logic        sq_sda;

	res_t expected_levels[$];

	// stimulus knobs
	bit    idle_on;
	int    refuse_pct;
	int    busy_cmd_pct;
	fill_t read_fill;
	bit    refusing;
	int    hold_len;

	int mismatches;
	int beats_checked;
	int ticks_sent;
	int writes_done;
	int reads_done;
	int ack_misses;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit in_ack(phase_t p);
		return p == PH_ACKDEVW || p == PH_ACKADDR || p == PH_ACKDATA || p == PH_ACKDEVR;
	endfunction

	function automatic void sequencer_reset();
		sq_cfg.device_address = RST_DEVICE_ADDRESS;
		sq_cfg.ack_timeout    = RST_ACK_TIMEOUT;
		sq_cfg.phase_ticks    = RST_PHASE_TICKS;
		sq_cfg.write_recovery = RST_WRITE_RECOVERY;
		sq_cfg.read_recovery  = RST_READ_RECOVERY;
		sq_phase   = PH_IDLE;
		sq_bits    = '0;
		sq_shift   = '0;
		sq_wait    = '0;
		sq_slot    = '0;
		sq_mode    = 1'b0;
		sq_addr    = '0;
		sq_data    = '0;
		sq_ack_err = 1'b0;
		sq_scl     = 1'b1;
		sq_sda     = 1'b1;
	endfunction

	function automatic void drive_levels();
		case (sq_phase)
			PH_START, PH_RSTART: begin
				case (sq_slot)
					2'd0: sq_sda = 1'b1;
					2'd1: sq_scl = 1'b1;
					2'd2: sq_sda = 1'b0;
					default: sq_scl = 1'b0;
				endcase
			end
			PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
				if (sq_slot == 2'd0)
					sq_scl = 1'b0;
				else if (sq_slot == 2'd1)
					sq_sda = (sq_bits < 4'd8) ? sq_shift[7] : 1'b1;
				else
					sq_scl = 1'b1;
			end
			PH_ACKDEVW, PH_ACKADDR, PH_ACKDATA, PH_ACKDEVR: begin
				if (sq_slot == 2'd0) begin
					sq_scl = 1'b1;
					sq_sda = 1'b1;
				end else begin
					sq_scl = 1'b0;
				end
			end
			PH_READ: begin
				case (sq_slot)
					2'd0: sq_scl = 1'b0;
					2'd1: sq_sda = 1'b1;
					2'd2: sq_scl = 1'b1;
					default: sq_scl = 1'b0;
				endcase
			end
			PH_NACK: begin
				if (sq_slot == 2'd0)
					sq_sda = 1'b1;
				else if (sq_slot == 2'd1)
					sq_scl = 1'b1;
				else
					sq_scl = 1'b0;
			end
			PH_STOP: begin
				if (sq_slot == 2'd0)
					sq_sda = 1'b0;
				else if (sq_slot == 2'd1)
					sq_scl = 1'b1;
				else
					sq_sda = 1'b1;
			end
			default: begin
				sq_scl = 1'b1;
				sq_sda = 1'b1;
			end
		endcase
	endfunction

	function automatic void goto_slot(phase_t p, logic [1:0] s);
		sq_phase = p;
		sq_slot  = s;
		sq_wait  = (sq_cfg.phase_ticks != 0) ? 16'(sq_cfg.phase_ticks - 8'd1) : 16'd0;
		drive_levels();
	endfunction

	function automatic void load_byte(phase_t p, logic [7:0] b);
		sq_shift = b;
		sq_bits  = '0;
		goto_slot(p, 2'd0);
	endfunction

	function automatic void step_slot(logic sda_in);
		phase_t p;
		p = sq_phase;
		case (p)
			PH_START, PH_RSTART: begin
				if (sq_slot < 2'd3)
					goto_slot(p, sq_slot + 2'd1);
				else if (p == PH_START)
					load_byte(PH_DEVW, {sq_cfg.device_address, 1'b0});
				else
					load_byte(PH_DEVR, {sq_cfg.device_address, 1'b1});
			end
			PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
				if (sq_bits < 4'd8) begin
					if (sq_slot < 2'd2) begin
						goto_slot(p, sq_slot + 2'd1);
					end else begin
						sq_shift = sq_shift << 1;
						sq_bits  = sq_bits + 4'd1;
						goto_slot(p, 2'd0);
					end
				end else if (sq_slot < 2'd1) begin
					goto_slot(p, 2'd1);
				end else begin
					// ack wait starts with no hold count
					sq_phase = phase_t'(p + 1);
					sq_slot  = 2'd0;
					sq_wait  = '0;
					drive_levels();
				end
			end
			PH_ACKDEVW: load_byte(PH_ADDR, sq_addr);
			PH_ACKADDR: begin
				if (sq_mode)
					goto_slot(PH_RSTART, 2'd0);
				else
					load_byte(PH_DATA, sq_data);
			end
			PH_ACKDATA: goto_slot(PH_STOP, 2'd0);
			PH_ACKDEVR: begin
				sq_bits  = '0;
				sq_shift = '0;
				goto_slot(PH_READ, 2'd0);
			end
			PH_READ: begin
				if (sq_slot < 2'd2) begin
					goto_slot(p, sq_slot + 2'd1);
				end else if (sq_slot == 2'd2) begin
					sq_shift = {sq_shift[6:0], sda_in};
					goto_slot(p, 2'd3);
				end else if (sq_bits < 4'd7) begin
					sq_bits = sq_bits + 4'd1;
					goto_slot(p, 2'd2);
				end else begin
					goto_slot(PH_NACK, 2'd0);
				end
			end
			PH_NACK: begin
				if (sq_slot < 2'd2)
					goto_slot(p, sq_slot + 2'd1);
				else
					goto_slot(PH_STOP, 2'd0);
			end
			PH_STOP: begin
				if (sq_slot < 2'd2) begin
					goto_slot(p, sq_slot + 2'd1);
				end else begin
					sq_phase = PH_RECOVER;
					sq_slot  = 2'd0;
					drive_levels();
					sq_wait  = sq_mode ? sq_cfg.read_recovery : sq_cfg.write_recovery;
				end
			end
			default: begin
				sq_phase = PH_IDLE;
				sq_slot  = 2'd0;
				sq_wait  = '0;
				drive_levels();
			end
		endcase
	endfunction

	function automatic res_t predict_levels(cmd_t c);
		res_t r;
		logic done;
		done = 1'b0;
		if (sq_phase == PH_IDLE) begin
			if (c.cmd_valid) begin
				sq_mode    = c.mode;
				sq_addr    = c.mem_address;
				sq_data    = c.write_data;
				sq_ack_err = 1'b0;
				sq_shift   = '0;
				goto_slot(PH_START, 2'd0);
			end
		end else if (sq_phase == PH_RECOVER) begin
			if (sq_wait == 0) begin
				sq_phase = PH_IDLE;
				done = 1'b1;
			end else begin
				sq_wait = sq_wait - 16'd1;
			end
		end else if (in_ack(sq_phase) && sq_slot == 2'd0) begin
			if (!c.sda_sample) begin
				goto_slot(sq_phase, 2'd1);
			end else begin
				sq_wait = sq_wait + 16'd1;
				if (sq_wait >= sq_cfg.ack_timeout) begin
					sq_ack_err = 1'b1;
					goto_slot(sq_phase, 2'd1);
				end
			end
		end else if (sq_wait > 0) begin
			sq_wait = sq_wait - 16'd1;
		end else begin
			step_slot(c.sda_sample);
		end
		if (done) begin
			if (sq_mode)
				reads_done++;
			else
				writes_done++;
			if (sq_ack_err)
				ack_misses++;
		end
		r.scl_level   = sq_scl;
		r.sda_release = sq_sda;
		r.busy_res    = sq_phase != PH_IDLE;
		r.done_res    = done;
		r.read_data   = (done && sq_mode) ? sq_shift : 8'h00;
		r.ack_missing = done ? sq_ack_err : 1'b0;
		return r;
	endfunction

	// plays the memory device: acks, read bits, and noise elsewhere
	function automatic cmd_t make_tick();
		cmd_t c;
		c.mem_address = 8'($urandom);
		c.write_data  = 8'($urandom);
		c.mode        = 1'($urandom);
		c.sda_sample  = 1'($urandom);
		c.cmd_valid   = (sq_phase != PH_IDLE) && ($urandom_range(0, 99) < busy_cmd_pct);
		if (in_ack(sq_phase) && sq_slot == 2'd0) begin
			if (sq_wait == 0)
				refusing = $urandom_range(0, 99) < refuse_pct;
			c.sda_sample = refusing ? 1'b1 : ($urandom_range(0, 3) == 0);
		end else if (sq_phase == PH_READ && read_fill != FILL_RANDOM) begin
			c.sda_sample = (read_fill == FILL_ONES);
		end
		return c;
	endfunction

	task automatic send_tick(cmd_t c);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.data  <= c;
		do @(posedge clk); while (!tick_bus.ready);
		expected_levels.push_back(predict_levels(c));
		ticks_sent++;
	endtask

	task automatic run_command(logic mode, logic [7:0] addr, logic [7:0] data);
		cmd_t c;
		int lead;
		lead = idle_on ? $urandom_range(0, 3) : 0;
		repeat (lead) send_tick(make_tick());
		c = make_tick();
		c.cmd_valid   = 1'b1;
		c.mode        = mode;
		c.mem_address = addr;
		c.write_data  = data;
		send_tick(c);
		do send_tick(make_tick()); while (sq_phase != PH_IDLE);
	endtask

	task automatic settle();
		tick_bus.valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_WIDTH-1:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		case (idx)
			REG_DEVICE_ADDRESS: sq_cfg.device_address = v[6:0];
			REG_ACK_TIMEOUT:    sq_cfg.ack_timeout    = v[7:0];
			REG_PHASE_TICKS:    sq_cfg.phase_ticks    = v[7:0];
			REG_WRITE_RECOVERY: sq_cfg.write_recovery = v;
			REG_READ_RECOVERY:  sq_cfg.read_recovery  = v;
			default: ;
		endcase
	endtask

	// upper data bits beyond each register's width carry junk on purpose
	task automatic set_config(logic [6:0] dev, logic [7:0] ato, logic [7:0] pt,
			logic [15:0] wrec, logic [15:0] rrec);
		logic [15:0] junk;
		junk = 16'($urandom);
		settle();
		write_reg(REG_DEVICE_ADDRESS, {junk[15:7], dev});
		write_reg(REG_ACK_TIMEOUT, {junk[15:8], ato});
		write_reg(REG_PHASE_TICKS, {junk[7:0], pt});
		write_reg(REG_WRITE_RECOVERY, wrec);
		write_reg(REG_READ_RECOVERY, rrec);
		wr_en <= 1'b0;
	endtask

	task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] beat %0d %s: expected %0h, got %0h",
				$realtime, beats_checked, field, want, got);
	endtask

	always @(posedge clk) begin : level_checker
		res_t want;
		res_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = res_bus.data;
			if (expected_levels.size() == 0) begin
				note_mismatch("unexpected beat", 8'h00, 8'h01);
			end else begin
				want = expected_levels.pop_front();
				if (got.scl_level !== want.scl_level)
					note_mismatch("scl_level", 8'(want.scl_level), 8'(got.scl_level));
				if (got.sda_release !== want.sda_release)
					note_mismatch("sda_release", 8'(want.sda_release),
						8'(got.sda_release));
				if (got.busy_res !== want.busy_res)
					note_mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				if (got.done_res !== want.done_res)
					note_mismatch("done_res", 8'(want.done_res), 8'(got.done_res));
				if (got.read_data !== want.read_data)
					note_mismatch("read_data", want.read_data, got.read_data);
				if (got.ack_missing !== want.ack_missing)
					note_mismatch("ack_missing", 8'(want.ack_missing),
						8'(got.ack_missing));
			end
			beats_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_bus.valid && tick_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Stalled for %0d cycles with %0d beats pending", quiet,
					expected_levels.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int stall;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 12) : 0;
			if (hold_len > 0) begin
				stall    = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	task automatic test_reset_defaults();
		idle_on      = 1'b1;
		busy_cmd_pct = 0;
		refuse_pct   = 0;
		read_fill    = FILL_ZEROS;
		run_command(1'b0, 8'h00, 8'hff);
		run_command(1'b1, 8'hff, 8'h00);
	endtask

	task automatic test_field_extremes();
		set_config(7'h7f, 8'd1, 8'd1, 16'd0, 16'd0);
		refuse_pct = 0;
		read_fill  = FILL_ONES;
		run_command(1'b1, 8'hff, 8'hff);
	endtask

	task automatic test_zero_counts();
		// zero hold and zero timeout both behave as one
		set_config(7'h2a, 8'd0, 8'd0, 16'd3, 16'd1);
		refuse_pct = 100;
		run_command(1'b1, 8'he7, 8'h00);
		refuse_pct = 0;
	endtask

	task automatic test_commands_while_busy();
		set_config(7'h50, 8'd4, 8'd1, 16'd2, 16'd2);
		busy_cmd_pct = 100;
		refuse_pct   = 20;
		run_command(1'b0, 8'h12, 8'h34);
		busy_cmd_pct = 0;
	endtask

	task automatic test_unused_indexes();
		settle();
		for (int i = int'(REG_READ_RECOVERY) + 1; i < 2 ** IDX_WIDTH; i++)
			write_reg(reg_idx_t'(i), CFG_WIDTH'($urandom));
		wr_en <= 1'b0;
		run_command(1'b0, 8'h9a, 8'hbc);
	endtask

	task automatic test_random_traffic();
		read_fill = FILL_RANDOM;
		set_config(7'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 2)),
			16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
		idle_on      = 1'b1;
		refuse_pct   = $urandom_range(0, 30);
		busy_cmd_pct = $urandom_range(0, 20);
		run_command(1'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_result_backpressure();
		set_config(7'h51, 8'd4, 8'd2, 16'd2, 16'd2);
		idle_on      = 1'b0;
		refuse_pct   = 0;
		busy_cmd_pct = 10;
		hold_len     = 300;
		run_command(1'b0, 8'h88, 8'h99);
		idle_on = 1'b1;
	endtask

	initial begin
		tick_bus.valid <= 1'b0;
		tick_bus.data  <= '0;
		wr_en          <= 1'b0;
		wr_index       <= '0;
		wr_data        <= '0;
		arst_n         <= 1'b0;
		hold_len       = 0;
		idle_on        = 1'b1;
		refuse_pct     = 0;
		busy_cmd_pct   = 0;
		read_fill      = FILL_RANDOM;
		refusing       = 1'b0;
		sequencer_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_zero_counts();
		test_commands_while_busy();
		test_unused_indexes();
		test_random_traffic();
		test_result_backpressure();

		settle();
		repeat (8) @(posedge clk);
		$display("Ran %0d bus ticks, %0d level beats checked", ticks_sent, beats_checked);
		$display("Finished %0d writes and %0d reads, %0d with an acknowledge timeout",
			writes_done, reads_done, ack_misses);
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_ifs.sv
hw/rtl/i2cee_front.sv
hw/rtl/i2cee_back.sv
hw/rtl/i2c_eeprom_byte_master_core.sv
tb/i2c_eeprom_byte_master_core_test.sv
